[hw/rtl/ptw_pkg.sv]
// Shared types, constants and the control program of the page table walker.
// Depends on nothing; the walker core and its testbench import it.
`default_nettype none

package ptw_pkg;

   // fixed geometry of the walk
   localparam int FRAMES_DEFAULT    = 64;
   localparam int ENTRIES_PER_TABLE = 512;
   localparam int PAGE_BYTES        = 4096;
   localparam int LEVEL_BITS        = $clog2(ENTRIES_PER_TABLE);
   localparam int OFFSET_W          = $clog2(PAGE_BYTES);
   localparam int TOP_SHIFT         = 39;
   localparam int VA_W              = 48;
   localparam int PA_W              = 18;
   localparam int FLAG_W            = 12;
   localparam int CSR_ADDR_W        = 3;
   localparam int CSR_DATA_W        = 32;

   localparam logic [1:0]        LAST_LEVEL       = 2'd3;
   localparam logic [FLAG_W-1:0] TABLE_FLAGS_INIT = 12'd1027;
   localparam logic [FLAG_W-1:0] PAGE_FLAGS_INIT  = 12'd1095;

   // operation codes
   localparam logic OP_LOOKUP = 1'b0;
   localparam logic OP_CREATE = 1'b1;

   // status codes
   localparam logic [1:0] STATUS_OK         = 2'd0;
   localparam logic [1:0] STATUS_NOT_MAPPED = 2'd1;
   localparam logic [1:0] STATUS_NO_FRAMES  = 2'd2;

   // register indexes (register select bit of the byte address)
   localparam logic CSR_TABLE_FLAGS = 1'b0;
   localparam logic CSR_PAGE_FLAGS  = 1'b1;

   typedef struct packed {
      logic            operation;
      logic [VA_W-1:0] virtual_address;
   } req_type;

   typedef struct packed {
      logic [1:0]      status;
      logic [PA_W-1:0] physical_address;
      logic            page_created;
      logic [1:0]      tables_created;
   } rsp_type;

   // program steps
   typedef enum logic [2:0] {
      UC_CLEAR,
      UC_IDLE,
      UC_READ,
      UC_CHECK,
      UC_MISS,
      UC_ALLOC,
      UC_DONE
   } step_type;

   // branch conditions
   typedef enum logic [2:0] {
      COND_ALWAYS,
      COND_CLEAR_LAST,
      COND_ACCEPT,
      COND_DESCEND,
      COND_PRESENT,
      COND_GROW,
      COND_OUT_FREE
   } cond_type;

   // one control word
   typedef struct packed {
      logic     clear_wr;
      logic     take_item;
      logic     mem_rd;
      logic     follow;
      logic     alloc;
      logic     emit;
      cond_type cond;
      step_type on_true;
      step_type on_false;
   } ucode_word_type;

   // control program rom
   function automatic ucode_word_type ucode_rom(step_type step);
      ucode_word_type w;
      w          = '0;
      w.cond     = COND_ALWAYS;
      w.on_true  = UC_IDLE;
      w.on_false = UC_IDLE;
      case (step)
         UC_CLEAR: begin
            w.clear_wr = 1'b1;
            w.cond     = COND_CLEAR_LAST;
            w.on_true  = UC_IDLE;
            w.on_false = UC_CLEAR;
         end
         UC_IDLE: begin
            w.take_item = 1'b1;
            w.cond      = COND_ACCEPT;
            w.on_true   = UC_READ;
            w.on_false  = UC_IDLE;
         end
         UC_READ: begin
            w.mem_rd   = 1'b1;
            w.on_true  = UC_CHECK;
            w.on_false = UC_CHECK;
         end
         UC_CHECK: begin
            w.follow   = 1'b1;
            w.cond     = COND_DESCEND;
            w.on_true  = UC_READ;
            w.on_false = UC_MISS;
         end
         UC_MISS: begin
            w.cond     = COND_PRESENT;
            w.on_true  = UC_DONE;
            w.on_false = UC_ALLOC;
         end
         UC_ALLOC: begin
            w.alloc    = 1'b1;
            w.cond     = COND_GROW;
            w.on_true  = UC_READ;
            w.on_false = UC_DONE;
         end
         UC_DONE: begin
            w.emit     = 1'b1;
            w.cond     = COND_OUT_FREE;
            w.on_true  = UC_IDLE;
            w.on_false = UC_DONE;
         end
         default: begin
            w.on_true  = UC_IDLE;
            w.on_false = UC_IDLE;
         end
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

[hw/rtl/four_level_page_table_walker_core.sv]
// Four-level page table walker: microcoded control over one table RAM.
// Depends on ptw_pkg and ptw_ram.
`default_nettype none

// Translates a 48-bit virtual address through a four-level, 4 KiB-granule
// table kept in a local RAM of FRAMES frames (frame 0 is the root). A lookup
// faults on an absent entry; a create allocates frames from a bump allocator
// and writes table and page descriptors with the programmed flags. After
// reset the RAM is swept to zero, one entry per cycle over all FRAMES*512
// entries (32768 at the default size); no request is taken until the sweep
// is done, while register writes are taken at any time. A walk runs on a
// small control program, one step per cycle, with every table access going
// to the one table RAM. The steps: an accept step, a read and a check step
// per level, a miss and an allocate step for an absent entry (the allocate
// step writes a descriptor for a fresh frame on a create, else fails the
// walk), a miss step after a last-level hit, and a result step. The result
// sits in an output register, so a stalled consumer does not hold up the
// next walk until that walk has its own result ready.

module four_level_page_table_walker_core
   import ptw_pkg::*;
#(
   parameter int FRAMES = FRAMES_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request channel
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire req_type               req_data,
   // result channel
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output rsp_type                    rsp_data,
   // register port
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic      [CSR_DATA_W-1:0] prdata,
   output logic                       pready
);

   localparam int FRAME_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
   localparam int NF_W    = $clog2(FRAMES + 1);
   localparam int ADDR_W  = FRAME_W + LEVEL_BITS;
   localparam int DEPTH   = FRAMES * ENTRIES_PER_TABLE;
   localparam int ENTRY_W = FRAME_W + FLAG_W;

   // control state
   step_type                  pc_ff, pc_in;
   logic [ADDR_W-1:0]         clr_ff, clr_in;
   logic [NF_W-1:0]           next_free_ff, next_free_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [FLAG_W-1:0]         table_flags_ff, table_flags_in;
   logic [FLAG_W-1:0]         page_flags_ff, page_flags_in;

   // walk datapath
   logic                      op_ff, op_in;
   logic [VA_W-1:0]           va_ff, va_in;
   logic [FRAME_W-1:0]        frame_ff, frame_in;
   logic [1:0]                lvl_ff, lvl_in;
   logic                      last_ff, last_in;
   logic [ADDR_W-1:0]         slot_ff, slot_in;
   logic [1:0]                status_ff, status_in;
   logic                      made_page_ff, made_page_in;
   logic [1:0]                made_tables_ff, made_tables_in;
   rsp_type                   rsp_ff, rsp_in;

   ucode_word_type            uw;
   logic                      branch;
   logic [LEVEL_BITS-1:0]     level_index;
   logic [ENTRY_W-1:0]        rd_entry;
   logic [FRAME_W-1:0]        child;
   logic                      present;
   logic                      can_create;
   logic                      out_free;
   logic                      csr_wr;
   logic                      mem_we;
   logic [ADDR_W-1:0]         mem_waddr;
   logic [ENTRY_W-1:0]        mem_wdata;
   logic [ADDR_W-1:0]         mem_raddr;
   logic [PA_W+FRAME_W+OFFSET_W-1:0] pa_wide;

   // control word of the current step
   assign uw = ucode_rom(pc_ff);

   // decode of the walk datapath
   assign level_index = va_ff[(TOP_SHIFT - LEVEL_BITS * int'(lvl_ff)) +: LEVEL_BITS];
   assign child       = rd_entry[OFFSET_W +: FRAME_W];
   assign present     = (child != '0);
   assign can_create  = (op_ff == OP_CREATE) && (next_free_ff != NF_W'(FRAMES));
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign pa_wide     = {{PA_W{1'b0}}, frame_ff, va_ff[OFFSET_W-1:0]};

   // table ram ports
   assign mem_we    = uw.clear_wr || (uw.alloc && can_create);
   assign mem_waddr = uw.clear_wr ? clr_ff : slot_ff;
   assign mem_wdata = uw.clear_wr ? '0
                    : {next_free_ff[FRAME_W-1:0], (last_ff ? page_flags_ff : table_flags_ff)};
   assign mem_raddr = {frame_ff, level_index};

   ptw_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (DEPTH)
   ) u_table_ram (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .re    (uw.mem_rd),
      .raddr (mem_raddr),
      .rdata (rd_entry)
   );

   // branch condition
   always_comb begin
      case (uw.cond)
         COND_ALWAYS:     branch = 1'b1;
         COND_CLEAR_LAST: branch = (clr_ff == ADDR_W'(DEPTH - 1));
         COND_ACCEPT:     branch = req_valid;
         COND_DESCEND:    branch = present && (lvl_ff != LAST_LEVEL);
         COND_PRESENT:    branch = present;
         COND_GROW:       branch = can_create && !last_ff;
         COND_OUT_FREE:   branch = out_free;
         default:         branch = 1'b0;
      endcase
   end

   // handshakes and register port
   assign req_stall = !uw.take_item;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign pready    = 1'b1;
   assign csr_wr    = psel && penable && pwrite && pready;
   assign prdata    = (paddr[2] == CSR_PAGE_FLAGS)
                    ? CSR_DATA_W'(page_flags_ff) : CSR_DATA_W'(table_flags_ff);

   // next state of sequencer and datapath
   always_comb begin
      pc_in          = branch ? uw.on_true : uw.on_false;
      clr_in         = clr_ff;
      next_free_in   = next_free_ff;
      rsp_valid_in   = rsp_valid_ff;
      table_flags_in = table_flags_ff;
      page_flags_in  = page_flags_ff;
      op_in          = op_ff;
      va_in          = va_ff;
      frame_in       = frame_ff;
      lvl_in         = lvl_ff;
      last_in        = last_ff;
      slot_in        = slot_ff;
      status_in      = status_ff;
      made_page_in   = made_page_ff;
      made_tables_in = made_tables_ff;
      rsp_in         = rsp_ff;

      // register writes
      if (csr_wr) begin
         if (paddr[2] == CSR_TABLE_FLAGS) begin
            table_flags_in = pwdata[FLAG_W-1:0];
         end else begin
            page_flags_in = pwdata[FLAG_W-1:0];
         end
      end

      // clearing sweep
      if (uw.clear_wr) begin
         clr_in = clr_ff + 1'b1;
      end

      // new walk
      if (uw.take_item && req_valid) begin
         op_in          = req_data.operation;
         va_in          = req_data.virtual_address;
         frame_in       = '0;
         lvl_in         = '0;
         status_in      = STATUS_OK;
         made_page_in   = 1'b0;
         made_tables_in = '0;
      end

      // remember the slot being read
      if (uw.mem_rd) begin
         slot_in = mem_raddr;
      end

      // step down through a present entry
      if (uw.follow) begin
         if (present) begin
            frame_in = child;
         end
         last_in = (lvl_ff == LAST_LEVEL);
         lvl_in  = lvl_ff + 1'b1;
      end

      // allocate a fresh frame or give up
      if (uw.alloc) begin
         if (can_create) begin
            frame_in     = next_free_ff[FRAME_W-1:0];
            next_free_in = next_free_ff + 1'b1;
            if (last_ff) begin
               made_page_in = 1'b1;
            end else begin
               made_tables_in = made_tables_ff + 1'b1;
            end
         end else begin
            status_in = (op_ff == OP_CREATE) ? STATUS_NO_FRAMES : STATUS_NOT_MAPPED;
         end
      end

      // output register
      if (uw.emit && out_free) begin
         rsp_valid_in            = 1'b1;
         rsp_in.status           = status_ff;
         rsp_in.physical_address = (status_ff == STATUS_OK) ? pa_wide[PA_W-1:0] : '0;
         rsp_in.page_created     = (status_ff == STATUS_OK) && made_page_ff;
         rsp_in.tables_created   = made_tables_ff;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff          <= UC_CLEAR;
         clr_ff         <= '0;
         next_free_ff   <= NF_W'(1);
         rsp_valid_ff   <= 1'b0;
         table_flags_ff <= TABLE_FLAGS_INIT;
         page_flags_ff  <= PAGE_FLAGS_INIT;
      end else begin
         pc_ff          <= pc_in;
         clr_ff         <= clr_in;
         next_free_ff   <= next_free_in;
         rsp_valid_ff   <= rsp_valid_in;
         table_flags_ff <= table_flags_in;
         page_flags_ff  <= page_flags_in;
      end
      op_ff          <= op_in;
      va_ff          <= va_in;
      frame_ff       <= frame_in;
      lvl_ff         <= lvl_in;
      last_ff        <= last_in;
      slot_ff        <= slot_in;
      status_ff      <= status_in;
      made_page_ff   <= made_page_in;
      made_tables_ff <= made_tables_in;
      rsp_ff         <= rsp_in;
   end

   // the allocator never runs past the last frame
   a_free_in_range: assert property (@(posedge clock) disable iff (reset)
      next_free_ff <= NF_W'(FRAMES))
      else $error("frame allocator beyond memory");

   // an allocation only ever fills an absent entry
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (pc_ff == UC_ALLOC && can_create) |-> !present)
      else $error("allocation over a present entry");

   // a new page is only reported on a successful walk
   a_page_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.page_created) |-> (rsp_ff.status == STATUS_OK))
      else $error("page reported on a failed walk");

   // a result is loaded only as the walk leaves its final step
   a_emit_then_idle: assert property (@(posedge clock) disable iff (reset)
      (pc_ff == UC_DONE && out_free) |=> (pc_ff == UC_IDLE && rsp_valid_ff))
      else $error("result step did not hand over");

endmodule

`default_nettype wire

[hw/rtl/ptw_ram.sv]
// Generic single write port, single read port RAM with registered read data.
// Depends on nothing.
`default_nettype none

module ptw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              we,
   input  wire logic [ADDR_W-1:0] waddr,
   input  wire logic [WIDTH-1:0]  wdata,
   input  wire logic              re,
   input  wire logic [ADDR_W-1:0] raddr,
   output logic      [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem[raddr];
      end
   end

endmodule

`default_nettype wire

[tb/tb_four_level_page_table_walker_core.sv]
// Self-checking testbench for four_level_page_table_walker_core: walks are
// predicted against a shadow copy of the table memory and frame allocator.
// Depends on ptw_pkg and the walker RTL only.
`timescale 1ns / 1ps

module tb_four_level_page_table_walker_core;
   import ptw_pkg::*;

   localparam int FRAMES       = FRAMES_DEFAULT;
   localparam int FRAME_W      = $clog2(FRAMES);
   localparam int IDLE_LIMIT   = 200000;
   localparam int PHASES       = 10;
   localparam int PHASE_ITEMS  = 170;
   localparam int HOLD_CYCLES  = 600;

   // clock, reset and block ports
   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_data;
   logic                  psel      = 1'b0;
   logic                  penable   = 1'b0;
   logic                  pwrite    = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr     = '0;
   logic [CSR_DATA_W-1:0] pwdata    = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   // shadow of the walker state
   bit [63:0]         shadow_tables [FRAMES*ENTRIES_PER_TABLE];
   int                shadow_next_frame  = 1;
   logic [FLAG_W-1:0] shadow_table_flags = TABLE_FLAGS_INIT;
   logic [FLAG_W-1:0] shadow_page_flags  = PAGE_FLAGS_INIT;

   // walks waiting to go in, translations waiting to come out
   req_type          pending_walks [$];
   rsp_type          expected_translations [$];
   logic [VA_W-1:0]  known_vas [$];

   int  mismatch_count = 0;
   int  quiet_cycles   = 0;
   int  gap_left       = 0;
   int  stall_left     = 0;
   int  hold_left      = 0;
   bit  sender_idles   = 1'b1;
   bit  receiver_idles = 1'b1;
   bit  hold_request   = 1'b0;

   four_level_page_table_walker_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // walk one address through the shadow tables, allocating in create mode
   function automatic rsp_type walk_translate(req_type walk);
      rsp_type             outcome;
      logic [FRAME_W-1:0]  frame;
      logic [FRAME_W-1:0]  fresh;
      logic [LEVEL_BITS-1:0] index;
      logic [FRAME_W+LEVEL_BITS-1:0] slot;
      logic [35:0]         child;
      logic [1:0]          made_tables;
      logic                made_page;
      bit                  finished;
      int                  lvl;
      int                  e;
      outcome     = '0;
      frame       = '0;
      made_tables = '0;
      made_page   = 1'b0;
      finished    = 1'b0;
      for (lvl = 0; lvl < 4 && !finished; lvl++) begin
         index = walk.virtual_address[TOP_SHIFT - LEVEL_BITS*lvl +: LEVEL_BITS];
         slot  = {frame, index};
         child = shadow_tables[slot][VA_W-1:OFFSET_W];
         if (child != '0) begin
            frame = child[FRAME_W-1:0];
         end else if (walk.operation == OP_LOOKUP) begin
            outcome.status = STATUS_NOT_MAPPED;
            finished       = 1'b1;
         end else if (shadow_next_frame >= FRAMES) begin
            // out of frames: tables made so far stay and are counted
            outcome.status         = STATUS_NO_FRAMES;
            outcome.tables_created = made_tables;
            finished               = 1'b1;
         end else begin
            fresh = FRAME_W'(shadow_next_frame);
            shadow_next_frame++;
            for (e = 0; e < ENTRIES_PER_TABLE; e++)
               shadow_tables[{fresh, LEVEL_BITS'(e)}] = '0;
            shadow_tables[slot] = (64'(fresh) << OFFSET_W) |
               64'(lvl < LAST_LEVEL ? shadow_table_flags : shadow_page_flags);
            if (lvl < LAST_LEVEL) made_tables++;
            else made_page = 1'b1;
            frame = fresh;
         end
      end
      if (!finished) begin
         outcome.status           = STATUS_OK;
         outcome.physical_address = {frame, walk.virtual_address[OFFSET_W-1:0]};
         outcome.page_created     = made_page;
         outcome.tables_created   = made_tables;
      end
      return outcome;
   endfunction

   function automatic void check_field(string field, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         mismatch_count++;
         $display("%0t %s mismatch: expected %0h actual %0h", $time, field, want, got);
      end
   endfunction

   function automatic logic [VA_W-1:0] va_of(logic [LEVEL_BITS-1:0] l0, logic [LEVEL_BITS-1:0] l1,
                                             logic [LEVEL_BITS-1:0] l2, logic [LEVEL_BITS-1:0] l3,
                                             logic [OFFSET_W-1:0] offset);
      return {l0, l1, l2, l3, offset};
   endfunction

   // mostly addresses of known mappings, some bent at one level, some noise
   function automatic req_type random_walk();
      req_type      walk;
      logic [63:0]  noise;
      int           pick;
      int           lvl;
      pick           = $urandom_range(99, 0);
      walk.operation = $urandom_range(1, 0) ? OP_CREATE : OP_LOOKUP;
      if (pick < 12 || known_vas.size() == 0) begin
         noise                = {$urandom, $urandom};
         walk.virtual_address = noise[VA_W-1:0];
      end else begin
         walk.virtual_address = known_vas[$urandom_range(known_vas.size() - 1, 0)];
         walk.virtual_address[OFFSET_W-1:0] = OFFSET_W'($urandom);
         if (pick >= 55) begin
            lvl = $urandom_range(3, 0);
            walk.virtual_address[TOP_SHIFT - LEVEL_BITS*lvl +: LEVEL_BITS] =
               LEVEL_BITS'($urandom);
         end
      end
      return walk;
   endfunction

   task automatic queue_walk(logic op, logic [VA_W-1:0] va);
      req_type walk;
      walk.operation       = op;
      walk.virtual_address = va;
      pending_walks.push_back(walk);
      if (op == OP_CREATE) known_vas.push_back(va);
   endtask

   // one register transfer: setup cycle then access cycle
   task automatic csr_transfer(logic wr, logic sel, logic [CSR_DATA_W-1:0] value,
                               output logic [CSR_DATA_W-1:0] read_back);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= wr;
      paddr   <= {sel, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      read_back = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // write both flag registers, then read them back
   task automatic program_flags(logic [CSR_DATA_W-1:0] table_value,
                                logic [CSR_DATA_W-1:0] page_value);
      logic [CSR_DATA_W-1:0] read_back;
      csr_transfer(1'b1, CSR_TABLE_FLAGS, table_value, read_back);
      shadow_table_flags = table_value[FLAG_W-1:0];
      csr_transfer(1'b1, CSR_PAGE_FLAGS, page_value, read_back);
      shadow_page_flags = page_value[FLAG_W-1:0];
      csr_transfer(1'b0, CSR_TABLE_FLAGS, '0, read_back);
      check_field("table flags readback", 64'(shadow_table_flags), 64'(read_back[FLAG_W-1:0]));
      csr_transfer(1'b0, CSR_PAGE_FLAGS, '0, read_back);
      check_field("page flags readback", 64'(shadow_page_flags), 64'(read_back[FLAG_W-1:0]));
   endtask

   // wait until every walk has gone in and every translation has come out
   task automatic drain();
      do @(posedge clock);
      while (pending_walks.size() != 0 || req_valid || expected_translations.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   // request driver: predicts each transfer, then offers the next walk after its gap
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_valid && !req_stall)
            expected_translations.push_back(walk_translate(req_data));
         if (!req_valid || !req_stall) begin
            if (gap_left != 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_walks.size() != 0) begin
               req_data  <= pending_walks.pop_front();
               req_valid <= 1'b1;
               gap_left = sender_idles ? $urandom_range(13, 0) : 0;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor and receiver back-pressure
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
         hold_left  = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_translations.size() == 0) begin
               mismatch_count++;
               $display("%0t unexpected result: expected none actual %0h", $time, rsp_data);
            end else begin
               want = expected_translations.pop_front();
               check_field("status", 64'(want.status), 64'(rsp_data.status));
               check_field("physical_address", 64'(want.physical_address),
                           64'(rsp_data.physical_address));
               check_field("page_created", 64'(want.page_created), 64'(rsp_data.page_created));
               check_field("tables_created", 64'(want.tables_created),
                           64'(rsp_data.tables_created));
            end
            stall_left = receiver_idles ? $urandom_range(13, 0) : 0;
         end
         if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (stall_left != 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= IDLE_LIMIT) begin
         $display("%0t timeout with %0d translations outstanding", $time,
                  expected_translations.size());
         $display("== FAIL ==");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      int spare;
      int ph;
      int n;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      program_flags(32'h0000_0000, 32'h0000_0FFF);

      // directed: misses, full creation, existing mappings, growth at each level
      queue_walk(OP_LOOKUP, va_of(0, 0, 0, 0, 0));
      queue_walk(OP_CREATE, va_of(0, 0, 0, 0, 0));
      queue_walk(OP_CREATE, va_of(0, 0, 0, 0, 12'hFFF));
      queue_walk(OP_LOOKUP, 48'hFFFF_FFFF_FFFF);
      queue_walk(OP_CREATE, 48'hFFFF_FFFF_FFFF);
      queue_walk(OP_LOOKUP, 48'hFFFF_FFFF_F000);
      queue_walk(OP_CREATE, va_of(0, 0, 0, 1, 0));
      queue_walk(OP_CREATE, va_of(0, 0, 1, 0, 12'h123));
      queue_walk(OP_CREATE, va_of(0, 1, 0, 0, 12'h800));
      queue_walk(OP_LOOKUP, va_of(0, 2, 0, 0, 0));
      queue_walk(OP_LOOKUP, va_of(0, 0, 2, 0, 0));
      queue_walk(OP_LOOKUP, va_of(0, 0, 0, 2, 0));
      drain();

      // use up the frames with fresh roots, ending in a partial and an empty failure
      spare = FRAMES - shadow_next_frame;
      for (n = 0; n < spare / 4 + 2; n++)
         queue_walk(OP_CREATE, va_of(LEVEL_BITS'(n + 1), LEVEL_BITS'($urandom),
                                     LEVEL_BITS'($urandom), LEVEL_BITS'($urandom),
                                     OFFSET_W'($urandom)));
      drain();

      // random phases over the built tables
      for (ph = 0; ph < PHASES; ph++) begin
         if (ph == 4) program_flags(32'hFFFF_FFFF, 32'h0000_0000);
         else if (ph == PHASES - 1) program_flags(32'h0000_0000, 32'h0000_0FFF);
         else program_flags($urandom, $urandom);
         sender_idles   = (ph % 4) != 2;
         receiver_idles = (ph % 4) < 2;
         for (n = 0; n < PHASE_ITEMS; n++)
            pending_walks.push_back(random_walk());
         // long receiver hold-off while walks keep coming
         if (ph == 5) hold_request = 1'b1;
         drain();
      end

      repeat (40) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

[files.f]
hw/rtl/ptw_pkg.sv
hw/rtl/ptw_ram.sv
hw/rtl/four_level_page_table_walker_core.sv
tb/tb_four_level_page_table_walker_core.sv
